>>> rtl/tzs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzs_pkg
// Shared types, codes, constants and the shade lookup of the torus shader.
// ----------------------------------------------------------------------------
package tzs_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 22;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [3:0] BLANK_CODE   = 4'd12;
    localparam logic [3:0] SHADE_MAX    = 4'd11;
    localparam logic [6:0] CHAR_SPACE   = 7'd32;
    localparam logic [6:0] CHAR_NEWLINE = 7'd10;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_PLOT  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_SIN_A = 2'd0,
        REG_COS_A = 2'd1,
        REG_SIN_B = 2'd2,
        REG_COS_B = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_DIV,
        ST_PMUL,
        ST_PSCALE,
        ST_COORD,
        ST_RD,
        ST_READ,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic sweep;
        logic mul1;
        logic mul2;
        logic sum;
        logic div_first;
        logic div_step;
        logic sum2;
        logic pmul;
        logic pscale;
        logic coord;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
    } t_status;

    function automatic logic [6:0] f_shade_char(input logic [3:0] code);
        logic [6:0] c;
        case (code)
            4'd0:    c = 7'd46;  // .
            4'd1:    c = 7'd44;  // ,
            4'd2:    c = 7'd45;  // -
            4'd3:    c = 7'd126; // ~
            4'd4:    c = 7'd58;  // :
            4'd5:    c = 7'd59;  // ;
            4'd6:    c = 7'd61;  // =
            4'd7:    c = 7'd33;  // !
            4'd8:    c = 7'd42;  // *
            4'd9:    c = 7'd35;  // #
            4'd10:   c = 7'd36;  // $
            4'd11:   c = 7'd64;  // @
            default: c = CHAR_SPACE;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/torus_point_zbuffer_shader_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torus_point_zbuffer_shader_core
// Character screen with depth store that plots rotated, projected torus points.
// ----------------------------------------------------------------------------
// Plot: multiply, multiply, sum, the 16-step restoring divider for the inverse
//   depth, projection, scale, coordinates, store read; one plot at a time.
// Read: reciprocal column test and registered store read.
// Clear: one store entry written per cycle, COLUMNS*ROWS entries in all.
// Reset: registers take their reset values, then a clearing pass blanks the
//   store before the first item is taken.
// ----------------------------------------------------------------------------
module torus_point_zbuffer_shader_core #(
    parameter int COLUMNS = tzs_pkg::DEF_COLUMNS,
    parameter int ROWS    = tzs_pkg::DEF_ROWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // item input
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_action,
    input  logic signed [15:0]          i_sin_theta,
    input  logic signed [15:0]          i_cos_theta,
    input  logic signed [15:0]          i_sin_phi,
    input  logic signed [15:0]          i_cos_phi,
    input  logic [10:0]                 i_cell_index,
    // result output
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [6:0]                  o_character,
    output logic                        o_written,
    output logic [10:0]                 o_written_index,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tzs_pkg::APB_AW-1:0]  paddr,
    input  logic [tzs_pkg::APB_DW-1:0]  pwdata,
    output logic [tzs_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    // sines and cosines of rotation angles A and B, Q1.14
    logic signed [15:0] w_sin_a, w_cos_a, w_sin_b, w_cos_b;

    // sequencer to datapath handshake
    tzs_pkg::t_cmd    w_cmd;
    tzs_pkg::t_status w_status;

    tzs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_sin_a (w_sin_a),
        .o_cos_a (w_cos_a),
        .o_sin_b (w_sin_b),
        .o_cos_b (w_cos_b)
    );

    // The sequencer owns the item and result handshakes; an item is taken only in idle, and a
    // finished result moves into the output register as soon as it is free.
    tzs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_action (i_action),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    // Datapath: multiply stages, divider, projection and the store itself.
    tzs_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_action        (i_action),
        .i_sin_theta     (i_sin_theta),
        .i_cos_theta     (i_cos_theta),
        .i_sin_phi       (i_sin_phi),
        .i_cos_phi       (i_cos_phi),
        .i_cell_index    (i_cell_index),
        .i_sin_a         (w_sin_a),
        .i_cos_a         (w_cos_a),
        .i_sin_b         (w_sin_b),
        .i_cos_b         (w_cos_b),
        .o_character     (o_character),
        .o_written       (o_written),
        .o_written_index (o_written_index)
    );

    // one item at a time: ready drops right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("item accepted while busy");

    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_valid || i_ready))
        else $error("pending result overwritten");

    // a loaded result shows up on the output
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> o_valid)
        else $error("loaded result not presented");

    // no item is taken while the store is being cleared
    a_sweep_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.sweep |-> !o_ready)
        else $error("ready during clearing pass");

endmodule

>>> rtl/tzs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tzs_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1760
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/tzs_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzs_regs
// APB register file holding the rotation sines and cosines.
// ----------------------------------------------------------------------------
module tzs_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tzs_pkg::APB_AW-1:0]  paddr,
    input  logic [tzs_pkg::APB_DW-1:0]  pwdata,
    output logic [tzs_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic signed [15:0]          o_sin_a,
    output logic signed [15:0]          o_cos_a,
    output logic signed [15:0]          o_sin_b,
    output logic signed [15:0]          o_cos_b
);

    tzs_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign w_idx  = tzs_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_sin_a <= 16'sd0;
            o_cos_a <= 16'sd16384;
            o_sin_b <= 16'sd0;
            o_cos_b <= 16'sd16384;
        end else if (w_wr) begin
            case (w_idx)
                tzs_pkg::REG_SIN_A: o_sin_a <= pwdata[15:0];
                tzs_pkg::REG_COS_A: o_cos_a <= pwdata[15:0];
                tzs_pkg::REG_SIN_B: o_sin_b <= pwdata[15:0];
                tzs_pkg::REG_COS_B: o_cos_b <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            tzs_pkg::REG_SIN_A: prdata = {16'd0, o_sin_a};
            tzs_pkg::REG_COS_A: prdata = {16'd0, o_cos_a};
            tzs_pkg::REG_SIN_B: prdata = {16'd0, o_sin_b};
            tzs_pkg::REG_COS_B: prdata = {16'd0, o_cos_b};
            default:            prdata = '0;
        endcase
    end

endmodule

>>> rtl/tzs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzs_ctrl
// Sequencer: steps the datapath through clear, plot and read items; other actions go straight to the result.
// ----------------------------------------------------------------------------
module tzs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_action,
    output logic              o_valid,
    input  logic              i_ready,
    output tzs_pkg::t_cmd     o_cmd,
    input  tzs_pkg::t_status  i_status
);

    tzs_pkg::t_state r_state, n_state;
    logic [3:0]      r_div_cnt;
    logic            r_item;
    logic            w_accept;

    assign o_ready  = (r_state == tzs_pkg::ST_IDLE);
    assign w_accept = o_ready && i_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tzs_pkg::ST_IDLE: begin
                if (i_valid) begin
                    case (tzs_pkg::t_action'(i_action))
                        tzs_pkg::ACT_CLEAR: n_state = tzs_pkg::ST_CLEAR;
                        tzs_pkg::ACT_PLOT:  n_state = tzs_pkg::ST_MUL1;
                        tzs_pkg::ACT_READ:  n_state = tzs_pkg::ST_READ;
                        default:            n_state = tzs_pkg::ST_FINISH;
                    endcase
                end
            end
            tzs_pkg::ST_CLEAR: begin
                if (i_status.sweep_last) begin
                    n_state = r_item ? tzs_pkg::ST_FINISH : tzs_pkg::ST_IDLE;
                end
            end
            tzs_pkg::ST_MUL1:   n_state = tzs_pkg::ST_MUL2;
            tzs_pkg::ST_MUL2:   n_state = tzs_pkg::ST_SUM;
            tzs_pkg::ST_SUM:    n_state = tzs_pkg::ST_DIV;
            tzs_pkg::ST_DIV: begin
                if (r_div_cnt == 4'd15) begin
                    n_state = tzs_pkg::ST_PMUL;
                end
            end
            tzs_pkg::ST_PMUL:   n_state = tzs_pkg::ST_PSCALE;
            tzs_pkg::ST_PSCALE: n_state = tzs_pkg::ST_COORD;
            tzs_pkg::ST_COORD:  n_state = tzs_pkg::ST_RD;
            tzs_pkg::ST_RD:     n_state = tzs_pkg::ST_FINISH;
            tzs_pkg::ST_READ:   n_state = tzs_pkg::ST_FINISH;
            tzs_pkg::ST_FINISH: begin
                if (!o_valid || i_ready) begin
                    n_state = tzs_pkg::ST_IDLE;
                end
            end
            default: n_state = tzs_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            tzs_pkg::ST_IDLE:   o_cmd.capture = i_valid;
            tzs_pkg::ST_CLEAR:  o_cmd.sweep = 1'b1;
            tzs_pkg::ST_MUL1:   o_cmd.mul1 = 1'b1;
            tzs_pkg::ST_MUL2:   o_cmd.mul2 = 1'b1;
            tzs_pkg::ST_SUM:    o_cmd.sum = 1'b1;
            tzs_pkg::ST_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_div_cnt == 4'd0);
                o_cmd.sum2      = (r_div_cnt == 4'd1);
            end
            tzs_pkg::ST_PMUL:   o_cmd.pmul = 1'b1;
            tzs_pkg::ST_PSCALE: o_cmd.pscale = 1'b1;
            tzs_pkg::ST_COORD:  o_cmd.coord = 1'b1;
            tzs_pkg::ST_FINISH: o_cmd.load_out = !o_valid || i_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tzs_pkg::ST_CLEAR;
            r_div_cnt <= 4'd0;
            r_item    <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= (r_state == tzs_pkg::ST_DIV) ? r_div_cnt + 4'd1 : 4'd0;
            if (w_accept) begin
                r_item <= (tzs_pkg::t_action'(i_action) == tzs_pkg::ACT_CLEAR);
            end else if (r_state == tzs_pkg::ST_CLEAR && i_status.sweep_last) begin
                r_item <= 1'b0;
            end
            if (o_cmd.load_out) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/tzs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzs_datapath
// Rotation, projection, divider, shading and the screen/depth store.
// ----------------------------------------------------------------------------
module tzs_datapath #(
    parameter int COLUMNS = tzs_pkg::DEF_COLUMNS,
    parameter int ROWS    = tzs_pkg::DEF_ROWS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tzs_pkg::t_cmd       i_cmd,
    output tzs_pkg::t_status    o_status,
    input  logic [1:0]          i_action,
    input  logic signed [15:0]  i_sin_theta,
    input  logic signed [15:0]  i_cos_theta,
    input  logic signed [15:0]  i_sin_phi,
    input  logic signed [15:0]  i_cos_phi,
    input  logic [10:0]         i_cell_index,
    input  logic signed [15:0]  i_sin_a,
    input  logic signed [15:0]  i_cos_a,
    input  logic signed [15:0]  i_sin_b,
    input  logic signed [15:0]  i_cos_b,
    output logic [6:0]          o_character,
    output logic                o_written,
    output logic [10:0]         o_written_index
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int RSH   = 11 + $clog2(COLUMNS);
    localparam int RMUL  = ((1 << RSH) + COLUMNS - 1) / COLUMNS;

    localparam logic signed [51:0] DEN_BIAS  = 52'sd5 <<< 42;
    localparam logic signed [51:0] DEN_SMALL = 52'sd1 <<< 42;
    localparam logic signed [63:0] X_SCALE   = 64'(COLUMNS / 4);
    localparam logic signed [63:0] Y_SCALE   = 64'(ROWS / 4);
    localparam logic signed [63:0] X_OFFS    = 64'(COLUMNS / 2) <<< 44;
    localparam logic signed [63:0] Y_OFFS    = 64'(ROWS / 2) <<< 44;
    localparam logic signed [63:0] RND44     = (64'sd1 <<< 44) - 64'sd1;

    // captured item
    tzs_pkg::t_action   r_action;
    logic signed [15:0] r_st, r_ct, r_sp, r_cp;
    logic [10:0]        r_cell;

    // products and partial sums
    logic signed [33:0] r_p, r_py;
    logic signed [31:0] r_cysa, r_cyca, r_spct, r_cpct;
    logic signed [49:0] r_psa, r_pca, r_pysb, r_pycb;
    logic signed [47:0] r_spctca, r_spctsa, r_cpctsb;
    logic signed [51:0] r_den, r_lpart, r_incb;
    logic signed [37:0] r_px;
    logic signed [35:0] r_inner;
    logic signed [53:0] r_pxcb, r_pxsb;
    logic signed [39:0] r_rx, r_ry;
    logic [3:0]         r_lum;
    logic               r_den_pos, r_den_small;
    logic [52:0]        r_rem;
    logic [15:0]        r_quo, r_invz;
    logic signed [57:0] r_xprod, r_yprod;
    logic signed [63:0] r_xs, r_ys;
    logic               r_on;
    logic [AW-1:0]      r_pidx;
    logic [AW-1:0]      r_sweep;
    logic [10:0]        r_q;

    // combinational
    logic signed [17:0] w_cx;
    logic signed [51:0] w_pxn, w_pxa, w_inn, w_inna, w_l;
    logic [52:0]        w_rem_sh;
    logic signed [54:0] w_rxn, w_rxa, w_ryn, w_rya;
    logic [15:0]        w_invz;
    logic signed [63:0] w_xa, w_ya;
    logic signed [19:0] w_x, w_y;
    logic [RSH+10:0]    w_qprod;
    logic               w_col0, w_in_range, w_pass;
    logic [3:0]         w_rd_code;
    logic [15:0]        w_rd_depth;
    logic [19:0]        w_rdata, w_wdata;
    logic [AW-1:0]      w_raddr, w_waddr;
    logic               w_we;
    logic [6:0]         w_char;
    logic               w_wr;
    logic [10:0]        w_widx;

    assign w_cx   = 18'(r_ct) + 18'sd32768;
    assign w_pxn  = 52'(r_pca) - (52'(r_cysa) <<< 14);
    assign w_pxa  = w_pxn + (w_pxn[51] ? 52'sd16383 : 52'sd0);
    assign w_inn  = (52'(r_cysa) <<< 14) - 52'(r_spctca);
    assign w_inna = w_inn + (w_inn[51] ? 52'sd16383 : 52'sd0);
    assign w_rxn  = 55'(r_pxcb) - 55'(r_pysb);
    assign w_rxa  = w_rxn + (w_rxn[54] ? 55'sd16383 : 55'sd0);
    assign w_ryn  = 55'(r_pxsb) + 55'(r_pycb);
    assign w_rya  = w_ryn + (w_ryn[54] ? 55'sd16383 : 55'sd0);
    assign w_l    = r_incb + r_lpart;
    assign w_rem_sh = {r_rem[51:0], 1'b0};
    assign w_invz = !r_den_pos ? 16'd0 : (r_den_small ? 16'hFFFF : r_quo);
    assign w_xa   = r_xs + (r_xs[63] ? RND44 : 64'sd0);
    assign w_ya   = r_ys + (r_ys[63] ? RND44 : 64'sd0);
    assign w_x    = 20'(w_xa >>> 44);
    assign w_y    = 20'(w_ya >>> 44);
    assign w_qprod = (RSH+11)'(r_cell) * (RSH+11)'(RMUL);

    assign o_status.sweep_last = (r_sweep == AW'(CELLS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep) begin
            r_sweep <= o_status.sweep_last ? '0 : r_sweep + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= w_qprod[RSH+10:RSH];
        if (i_cmd.capture) begin
            r_action <= tzs_pkg::t_action'(i_action);
            r_st     <= i_sin_theta;
            r_ct     <= i_cos_theta;
            r_sp     <= i_sin_phi;
            r_cp     <= i_cos_phi;
            r_cell   <= i_cell_index;
        end
        if (i_cmd.mul1) begin
            r_p    <= 34'(w_cx) * 34'(r_sp);
            r_py   <= 34'(w_cx) * 34'(r_cp);
            r_cysa <= 32'(r_st) * 32'(i_sin_a);
            r_cyca <= 32'(r_st) * 32'(i_cos_a);
            r_spct <= 32'(r_sp) * 32'(r_ct);
            r_cpct <= 32'(r_cp) * 32'(r_ct);
        end
        if (i_cmd.mul2) begin
            r_psa    <= 50'(r_p) * 50'(i_sin_a);
            r_pca    <= 50'(r_p) * 50'(i_cos_a);
            r_pysb   <= 50'(r_py) * 50'(i_sin_b);
            r_pycb   <= 50'(r_py) * 50'(i_cos_b);
            r_spctca <= 48'(r_spct) * 48'(i_cos_a);
            r_spctsa <= 48'(r_spct) * 48'(i_sin_a);
            r_cpctsb <= 48'(r_cpct) * 48'(i_sin_b);
        end
        if (i_cmd.sum) begin
            r_den   <= 52'(r_psa) + (52'(r_cyca) <<< 14) + DEN_BIAS;
            r_px    <= 38'(w_pxa >>> 14);
            r_inner <= 36'(w_inna >>> 14);
            r_lpart <= 52'sd0 - 52'(r_spctsa) - (52'(r_cyca) <<< 14) - 52'(r_cpctsb);
            r_rem   <= 53'd1 << 42;
            r_quo   <= 16'd0;
        end
        if (i_cmd.div_first) begin
            r_pxcb      <= 54'(r_px) * 54'(i_cos_b);
            r_pxsb      <= 54'(r_px) * 54'(i_sin_b);
            r_incb      <= 52'(r_inner) * 52'(i_cos_b);
            r_den_pos   <= (r_den > 52'sd0);
            r_den_small <= (r_den <= DEN_SMALL);
        end
        // restoring division step: one quotient bit
        if (i_cmd.div_step) begin
            if (w_rem_sh >= {1'b0, r_den}) begin
                r_rem <= w_rem_sh - {1'b0, r_den};
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_quo <= {r_quo[14:0], 1'b0};
            end
        end
        if (i_cmd.sum2) begin
            r_rx <= 40'(w_rxa >>> 14);
            r_ry <= 40'(w_rya >>> 14);
            if (w_l[51]) begin
                r_lum <= 4'd0;
            end else if (w_l[50:43] != 8'd0 || w_l[42:39] > tzs_pkg::SHADE_MAX) begin
                r_lum <= tzs_pkg::SHADE_MAX;
            end else begin
                r_lum <= w_l[42:39];
            end
        end
        if (i_cmd.pmul) begin
            r_invz  <= w_invz;
            r_xprod <= 58'($signed({1'b0, w_invz})) * 58'(r_rx);
            r_yprod <= 58'($signed({1'b0, w_invz})) * 58'(r_ry);
        end
        if (i_cmd.pscale) begin
            r_xs <= 64'(r_xprod) * X_SCALE + X_OFFS;
            r_ys <= 64'(r_yprod) * Y_SCALE + Y_OFFS;
        end
        if (i_cmd.coord) begin
            r_on   <= !w_x[19] && (w_x < 20'(COLUMNS)) && !w_y[19] && (w_y < 20'(ROWS));
            r_pidx <= AW'(w_x) + AW'(COLUMNS) * AW'(w_y);
        end
        if (i_cmd.load_out) begin
            o_character     <= w_char;
            o_written       <= w_wr;
            o_written_index <= w_widx;
        end
    end

    // store: {shade code, inverse depth}
    assign w_raddr = (r_action == tzs_pkg::ACT_PLOT) ? r_pidx : AW'(r_cell);
    assign w_rd_code  = w_rdata[19:16];
    assign w_rd_depth = w_rdata[15:0];

    assign w_pass     = r_on && (r_invz > w_rd_depth);
    assign w_in_range = (32'(r_cell) < 32'(CELLS));
    assign w_col0     = (22'(r_q) * 22'(COLUMNS)) == 22'(r_cell);

    always_comb begin
        w_char = tzs_pkg::CHAR_SPACE;
        w_wr   = 1'b0;
        w_widx = 11'd0;
        case (r_action)
            tzs_pkg::ACT_PLOT: begin
                w_wr   = w_pass;
                w_widx = r_on ? 11'(r_pidx) : 11'd0;
                if (w_pass) begin
                    w_char = tzs_pkg::f_shade_char(r_lum);
                end
            end
            tzs_pkg::ACT_READ: begin
                if (w_in_range) begin
                    w_char = w_col0 ? tzs_pkg::CHAR_NEWLINE : tzs_pkg::f_shade_char(w_rd_code);
                end
            end
            default: ;
        endcase
    end

    assign w_we    = i_cmd.sweep ||
                     (i_cmd.load_out && r_action == tzs_pkg::ACT_PLOT && w_pass);
    assign w_waddr = i_cmd.sweep ? r_sweep : r_pidx;
    assign w_wdata = i_cmd.sweep ? {tzs_pkg::BLANK_CODE, 16'd0} : {r_lum, r_invz};

    tzs_ram #(
        .WIDTH (20),
        .DEPTH (CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule
